>>> rtl/jadm_pkg.sv
package jadm_pkg;

	// converter full scale of an axis reading
	localparam int ADC_FULL_SCALE = 1023;
	localparam int ADC_W = $clog2(ADC_FULL_SCALE + 1);

	// reciprocal of full scale times 200, exact floor for every reading up to full scale
	localparam int PCT_SH = 32;
	localparam logic [63:0] PCT_MUL =
		((64'd200 << PCT_SH) + 64'(ADC_FULL_SCALE) - 64'd1) / 64'(ADC_FULL_SCALE);
	localparam int PCT_MUL_W = $clog2(PCT_MUL + 64'd1);
	localparam int PCT_PROD_W = ADC_W + PCT_MUL_W;

	// divide by 100 as multiply and shift, exact for products up to 200 * 255
	localparam int DIV100_SH = 23;
	localparam logic [16:0] DIV100_MUL = 17'(((64'd1 << DIV100_SH) + 64'd99) / 64'd100);

	// scaling divider: two quotient bits per stage
	localparam int DIV_BITS_PER_STAGE = 2;

	// pipeline depth from input register to output register
	localparam int NSTAGE = 11;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PWM = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE = 2'd1;

	// one load enable per pipeline stage
	typedef logic [NSTAGE:1] stage_en_t;

	// coding of a raw axis reading
	typedef enum logic [3:0] {
		CLS_PASS = 4'b0001,
		CLS_ADC  = 4'b0010,
		CLS_LOW  = 4'b0100,
		CLS_HIGH = 4'b1000
	} axis_cls_t;

	// one motor lane travelling through the scaling divider
	typedef struct packed {
		logic [16:0]       rem;
		logic [8:0]        divisor;
		logic [7:0]        quo;
		logic              scale;
		logic              neg;
		logic signed [8:0] plain;
	} div_lane_t;

endpackage

>>> rtl/jadm_axis.sv
module jadm_axis (
	input  logic                clk,
	input  jadm_pkg::stage_en_t en,
	input  logic [7:0]          max_pwm,
	input  logic [6:0]          deadzone_percent,
	input  logic signed [15:0]  raw,
	output logic [8:0]          scaled
);

	jadm_pkg::axis_cls_t cls_c;
	logic [jadm_pkg::PCT_PROD_W-1:0] pct_prod;

	jadm_pkg::axis_cls_t cls_s1;
	logic [7:0] pass_s1;
	logic [7:0] top_s1;

	logic signed [7:0] pct_c;
	logic [6:0] mag_c;
	logic signed [7:0] pct_s2;

	logic [7:0] off_c;
	logic [15:0] n_s3;

	logic [32:0] q_prod;
	logic [8:0] q_s4;

	// classify the raw reading
	always_comb begin
		priority if (raw >= -16'sd100 && raw <= 16'sd100) begin
			cls_c = jadm_pkg::CLS_PASS;
		end else if (raw[15]) begin
			cls_c = jadm_pkg::CLS_LOW;
		end else if ({1'b0, raw} <= 17'(jadm_pkg::ADC_FULL_SCALE)) begin
			cls_c = jadm_pkg::CLS_ADC;
		end else begin
			cls_c = jadm_pkg::CLS_HIGH;
		end
	end

	// converter reading times 200 over full scale
	assign pct_prod = jadm_pkg::PCT_PROD_W'(raw[jadm_pkg::ADC_W-1:0])
		* jadm_pkg::PCT_PROD_W'(jadm_pkg::PCT_MUL[jadm_pkg::PCT_MUL_W-1:0]);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			cls_s1 <= cls_c;
			pass_s1 <= raw[7:0];
			top_s1 <= pct_prod[jadm_pkg::PCT_SH +: 8];
		end
	end

	// percent select and deadzone
	always_comb begin
		unique case (cls_s1)
			jadm_pkg::CLS_PASS: pct_c = pass_s1;
			jadm_pkg::CLS_ADC:  pct_c = 8'(top_s1 - 8'd100);
			jadm_pkg::CLS_LOW:  pct_c = -8'sd100;
			jadm_pkg::CLS_HIGH: pct_c = 8'sd100;
			default:            pct_c = 8'sd0;
		endcase
		mag_c = 7'(pct_c[7] ? -pct_c : pct_c);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			pct_s2 <= (mag_c <= deadzone_percent) ? 8'sd0 : pct_c;
		end
	end

	// offset percent times max pwm
	assign off_c = 8'(pct_s2) + 8'd100;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			n_s3 <= 16'(off_c) * 16'(max_pwm);
		end
	end

	// divide by 100
	assign q_prod = 33'(n_s3) * 33'(jadm_pkg::DIV100_MUL);

	always_ff @(posedge clk) begin
		if (en[4]) begin
			q_s4 <= q_prod[jadm_pkg::DIV100_SH +: 9];
		end
	end

	assign scaled = q_s4;

endmodule

>>> rtl/jadm_mix.sv
module jadm_mix (
	input  logic                clk,
	input  jadm_pkg::stage_en_t en,
	input  logic [7:0]          max_pwm,
	input  logic [8:0]          turn_off,
	input  logic [8:0]          fwd_off,
	output jadm_pkg::div_lane_t lane_l,
	output jadm_pkg::div_lane_t lane_r
);

	logic signed [9:0] fwd_c;
	logic signed [9:0] turn_c;
	logic signed [9:0] left_s5;
	logic signed [9:0] right_s5;

	logic [8:0] al_c;
	logic [8:0] ar_c;
	logic [8:0] largest_c;
	logic scale_c;

	jadm_pkg::div_lane_t lane_l_s6;
	jadm_pkg::div_lane_t lane_r_s6;

	// remove the offset and mix the two axes
	assign fwd_c = $signed({1'b0, fwd_off}) - $signed({2'b00, max_pwm});
	assign turn_c = $signed({1'b0, turn_off}) - $signed({2'b00, max_pwm});

	always_ff @(posedge clk) begin
		if (en[5]) begin
			left_s5 <= fwd_c + turn_c;
			right_s5 <= fwd_c - turn_c;
		end
	end

	// magnitudes, largest and the scaling dividends
	assign al_c = 9'(left_s5[9] ? -left_s5 : left_s5);
	assign ar_c = 9'(right_s5[9] ? -right_s5 : right_s5);
	assign largest_c = (al_c > ar_c) ? al_c : ar_c;
	assign scale_c = largest_c > {1'b0, max_pwm};

	always_ff @(posedge clk) begin
		if (en[6]) begin
			lane_l_s6.rem <= 17'(al_c) * 17'(max_pwm);
			lane_l_s6.divisor <= largest_c;
			lane_l_s6.quo <= '0;
			lane_l_s6.scale <= scale_c;
			lane_l_s6.neg <= left_s5[9];
			lane_l_s6.plain <= 9'(left_s5);
			lane_r_s6.rem <= 17'(ar_c) * 17'(max_pwm);
			lane_r_s6.divisor <= largest_c;
			lane_r_s6.quo <= '0;
			lane_r_s6.scale <= scale_c;
			lane_r_s6.neg <= right_s5[9];
			lane_r_s6.plain <= 9'(right_s5);
		end
	end

	assign lane_l = lane_l_s6;
	assign lane_r = lane_r_s6;

endmodule

>>> rtl/jadm_div.sv
module jadm_div (
	input  logic                clk,
	input  jadm_pkg::stage_en_t en,
	input  jadm_pkg::div_lane_t lane_in,
	output jadm_pkg::div_lane_t lane_out
);

	jadm_pkg::div_lane_t div_s7;
	jadm_pkg::div_lane_t div_s8;
	jadm_pkg::div_lane_t div_s9;
	jadm_pkg::div_lane_t div_s10;

	// two restoring steps, quotient bits hi and hi-1
	function automatic jadm_pkg::div_lane_t div_step(
		input jadm_pkg::div_lane_t d,
		input logic [2:0] hi
	);
		jadm_pkg::div_lane_t r;
		logic [16:0] trial;
		logic [2:0] k;
		r = d;
		for (int b = 0; b < jadm_pkg::DIV_BITS_PER_STAGE; b++) begin
			k = hi - 3'(b);
			trial = 17'(r.divisor) << k;
			if (r.rem >= trial) begin
				r.rem = r.rem - trial;
				r.quo[k] = 1'b1;
			end
		end
		return r;
	endfunction

	// quotient bits 7 and 6
	always_ff @(posedge clk) begin
		if (en[7]) begin
			div_s7 <= div_step(lane_in, 3'd7);
		end
	end

	// quotient bits 5 and 4
	always_ff @(posedge clk) begin
		if (en[8]) begin
			div_s8 <= div_step(div_s7, 3'd5);
		end
	end

	// quotient bits 3 and 2
	always_ff @(posedge clk) begin
		if (en[9]) begin
			div_s9 <= div_step(div_s8, 3'd3);
		end
	end

	// quotient bits 1 and 0
	always_ff @(posedge clk) begin
		if (en[10]) begin
			div_s10 <= div_step(div_s9, 3'd1);
		end
	end

	assign lane_out = div_s10;

endmodule

>>> rtl/joystick_arcade_drive_mixer.sv
// Arcade drive mixer: each input beat carries a raw turn (raw_x) and forward (raw_y) reading,
// either a percent in -100..100 or a 101..1023 converter value, and gives one output beat with
// signed left and right motor drive in -max_pwm..max_pwm. The datapath is an 11-stage
// pipeline: one beat is accepted every cycle while in_stall is low. The stages are the four
// axis stages (three of them multiplies), the two mix stages, the four-stage scaling divider,
// which resolves two quotient bits per stage, and the output register. A stall on the
// output holds only the full stages; empty stages ahead keep filling, so in_stall rises
// only once every stage holds a beat. The configuration port is always ready; registers are
// read by the stages as beats pass, so a write also reaches beats in flight. The user must
// write them only while the block is idle; the block itself does not enforce this.
module joystick_arcade_drive_mixer (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [15:0]                raw_x,
	input  logic signed [15:0]                raw_y,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [8:0]                 left_pwm,
	output logic signed [8:0]                 right_pwm,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [jadm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [7:0]                        cfg_data
);

	logic [7:0] max_pwm_q;
	logic [6:0] deadzone_q;

	logic [jadm_pkg::NSTAGE:1] vld_q;
	jadm_pkg::stage_en_t en;

	logic [8:0] turn_off;
	logic [8:0] fwd_off;
	jadm_pkg::div_lane_t mix_l;
	jadm_pkg::div_lane_t mix_r;
	jadm_pkg::div_lane_t div_l;
	jadm_pkg::div_lane_t div_r;

	logic signed [8:0] left_c;
	logic signed [8:0] right_c;
	logic signed [8:0] left_s11;
	logic signed [8:0] right_s11;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pwm_q <= 8'd255;
			deadzone_q <= 7'd5;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				jadm_pkg::REG_MAX_PWM:  max_pwm_q <= cfg_data;
				jadm_pkg::REG_DEADZONE: deadzone_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// stage enables: a stage loads when empty or when the next one loads
	always_comb begin
		en[jadm_pkg::NSTAGE] = !vld_q[jadm_pkg::NSTAGE] || !out_stall;
		for (int i = jadm_pkg::NSTAGE - 1; i >= 1; i--) begin
			en[i] = !vld_q[i] || en[i+1];
		end
	end

	assign in_stall = !en[1];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int i = 2; i <= jadm_pkg::NSTAGE; i++) begin
				if (en[i]) begin
					vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// axis normalisation and pwm mapping
	jadm_axis u_axis_x (
		.clk              (clk),
		.en               (en),
		.max_pwm          (max_pwm_q),
		.deadzone_percent (deadzone_q),
		.raw              (raw_x),
		.scaled           (turn_off)
	);

	jadm_axis u_axis_y (
		.clk              (clk),
		.en               (en),
		.max_pwm          (max_pwm_q),
		.deadzone_percent (deadzone_q),
		.raw              (raw_y),
		.scaled           (fwd_off)
	);

	// differential mix
	jadm_mix u_mix (
		.clk      (clk),
		.en       (en),
		.max_pwm  (max_pwm_q),
		.turn_off (turn_off),
		.fwd_off  (fwd_off),
		.lane_l   (mix_l),
		.lane_r   (mix_r)
	);

	// scaling dividers, one per motor
	jadm_div u_div_l (
		.clk      (clk),
		.en       (en),
		.lane_in  (mix_l),
		.lane_out (div_l)
	);

	jadm_div u_div_r (
		.clk      (clk),
		.en       (en),
		.lane_in  (mix_r),
		.lane_out (div_r)
	);

	// pick scaled or plain value and restore the sign
	assign left_c = !div_l.scale ? div_l.plain
		: (div_l.neg ? 9'(9'd0 - {1'b0, div_l.quo}) : 9'({1'b0, div_l.quo}));
	assign right_c = !div_r.scale ? div_r.plain
		: (div_r.neg ? 9'(9'd0 - {1'b0, div_r.quo}) : 9'({1'b0, div_r.quo}));

	// output register
	always_ff @(posedge clk) begin
		if (en[jadm_pkg::NSTAGE]) begin
			left_s11 <= left_c;
			right_s11 <= right_c;
		end
	end

	assign out_valid = vld_q[jadm_pkg::NSTAGE];
	assign left_pwm = left_s11;
	assign right_pwm = right_s11;

endmodule

>>> rtl/jadm_check.sv
module jadm_check (
	input logic              clk,
	input logic              arst_n,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic signed [8:0] left_pwm,
	input logic signed [8:0] right_pwm
);

	// a stalled output beat stays and holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(left_pwm) && $stable(right_pwm))
		else $error("output beat changed while stalled");

	// the input only stalls behind a blocked output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with the output free");

	// drive values stay inside -255..255, the widest motor range
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> left_pwm != 9'h100 && right_pwm != 9'h100)
		else $error("drive value outside motor range");

endmodule

bind joystick_arcade_drive_mixer jadm_check u_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.left_pwm  (left_pwm),
	.right_pwm (right_pwm)
);
